// ===== rtl/mva_pkg.sv =====
// ----------------------------------------------------------------------------
// mva_pkg
// shared types and constants of the voice allocator
// ----------------------------------------------------------------------------
package mva_pkg;

    localparam int FM_VOICES_DEF  = 24;
    localparam int PSG_VOICES_DEF = 6;
    localparam int MAX_RESULTS    = 24;

    localparam logic [2:0] CMD_FM_ON    = 3'd0;
    localparam logic [2:0] CMD_FM_OFF   = 3'd1;
    localparam logic [2:0] CMD_DRUM     = 3'd2;
    localparam logic [2:0] CMD_FM_VOL   = 3'd3;
    localparam logic [2:0] CMD_PSG_ON   = 3'd4;
    localparam logic [2:0] CMD_PSG_OFF  = 3'd5;
    localparam logic [2:0] CMD_PSG_VOL  = 3'd6;
    localparam logic [2:0] CMD_DRUM_VOL = 3'd7;

    localparam logic [0:0] REG_DRUM_CH  = 1'b0;
    localparam logic [0:0] REG_PSG_CH   = 1'b1;

    localparam logic [6:0] CC_VOLUME     = 7'h07;
    localparam logic [6:0] CC_EXPRESSION = 7'h0B;
    localparam logic [5:0] DRUM_RESET    = 6'h20;

    localparam logic [3:0] OP_NOTE_OFF = 4'h8;
    localparam logic [3:0] OP_NOTE_ON  = 4'h9;
    localparam logic [3:0] OP_CTRL     = 4'hB;
    localparam logic [3:0] OP_PROG     = 4'hC;

    // voice entry in memory: used, channel, note, level, program
    typedef struct packed {
        logic       used;
        logic [3:0] chan;
        logic [6:0] note;
        logic [3:0] level;
        logic [6:0] prog;
    } t_voice;

    localparam int VOICE_W = $bits(t_voice);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_EVAL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [2:0] command;
        logic [4:0] voice_index;
        logic [6:0] note_number;
        logic [3:0] level_value;
        logic [6:0] program_number;
        logic [5:0] rhythm_mask;
        logic       last;
    } t_result;

    // drum note to bit, bit 3 set means not a drum note
    function automatic logic [3:0] drum_bit(input logic [6:0] note);
        case (note)
            7'h24:   drum_bit = 4'd4;
            7'h26:   drum_bit = 4'd3;
            7'h2F:   drum_bit = 4'd2;
            7'h31:   drum_bit = 4'd1;
            7'h2C:   drum_bit = 4'd0;
            7'h2E:   drum_bit = 4'd0;
            default: drum_bit = 4'd8;
        endcase
    endfunction

endpackage

// ===== rtl/mva_if.sv =====
// ----------------------------------------------------------------------------
// mva_byte_if / mva_cmd_if
// valid/ready channels for midi bytes and chip commands
// ----------------------------------------------------------------------------
interface mva_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] midi_byte;
    modport source (output valid, output midi_byte, input ready);
    modport sink   (input valid, input midi_byte, output ready);
endinterface

interface mva_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [4:0] voice_index;
    logic [6:0] note_number;
    logic [3:0] level_value;
    logic [6:0] program_number;
    logic [5:0] rhythm_mask;
    logic       last;
    modport source (output valid, output command, output voice_index, output note_number,
                    output level_value, output program_number, output rhythm_mask,
                    output last, input ready);
    modport sink   (input valid, input command, input voice_index, input note_number,
                    input level_value, input program_number, input rhythm_mask,
                    input last, output ready);
endinterface

// ===== rtl/midi_voice_allocator_core.sv =====
// ----------------------------------------------------------------------------
// midi_voice_allocator_core
// midi parser and fm/psg voice allocator, voice table in one ram
// ----------------------------------------------------------------------------
// flow: a status or ignored byte is taken in idle; a message byte that needs the table
//   goes to read, then to eval and out for each entry swept (a control also visits its
//   channel entry); out waits while a command transfer is still pending
// throughput: one byte at a time, set by the single ram port of the voice table
// reset: a clearing pass over all FM_VOICES+PSG_VOICES+16 entries writes zero entries,
//   no byte accepted during it; config back to drum 9, psg 15
module midi_voice_allocator_core #(
    parameter int FM_VOICES  = mva_pkg::FM_VOICES_DEF,
    parameter int PSG_VOICES = mva_pkg::PSG_VOICES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    mva_byte_if.sink    s_in,
    mva_cmd_if.source   m_out
);
    // ram layout: fm voices, then psg voices, then 16 channel entries
    localparam int DEPTH = FM_VOICES + PSG_VOICES + 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int PSG_BASE = FM_VOICES;
    localparam int CH_BASE  = FM_VOICES + PSG_VOICES;

    mva_pkg::t_state r_state, n_state;
    logic [7:0] r_status, n_status;
    logic       r_count, n_count;
    logic [7:0] r_first, n_first;
    logic [5:0] r_drum, n_drum;
    logic [3:0] r_drum_ch, r_psg_ch;

    // current message being worked
    logic [3:0] r_op, n_op;
    logic [3:0] r_ch, n_ch;
    logic [6:0] r_key, n_key;     // note or control number
    logic [6:0] r_data, n_data;   // program or second data
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_end, n_end;
    logic [4:0] r_nres, n_nres;
    logic       r_stop, n_stop;   // note-on done
    mva_pkg::t_result r_res, n_res;
    logic       r_pend, n_pend;   // a result held to learn whether it is last
    logic       r_ovalid, n_ovalid;
    mva_pkg::t_result r_ores, n_ores;

    logic          we;
    logic [AW-1:0] addr;
    mva_pkg::t_voice wdata, rdata;

    mva_ram #(.WIDTH(mva_pkg::VOICE_W), .DEPTH(DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wdata), .o_rdata(rdata)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drum_ch <= 4'd9;
            r_psg_ch  <= 4'd15;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mva_pkg::REG_DRUM_CH: r_drum_ch <= i_cfg_data;
                mva_pkg::REG_PSG_CH:  r_psg_ch  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mva_pkg::ST_CLEAR;
            r_status <= '0;
            r_count  <= 1'b0;
            r_first  <= '0;
            r_drum   <= mva_pkg::DRUM_RESET;
            r_addr   <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
            r_nres   <= '0;
            r_stop   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_count  <= n_count;
            r_first  <= n_first;
            r_drum   <= n_drum;
            r_addr   <= n_addr;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
            r_nres   <= n_nres;
            r_stop   <= n_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_ch   <= n_ch;
        r_key  <= n_key;
        r_data <= n_data;
        r_end  <= n_end;
        r_res  <= n_res;
        r_ores <= n_ores;
    end

    assign s_in.ready = (r_state == mva_pkg::ST_IDLE) && !r_ovalid;

    assign m_out.valid          = r_ovalid;
    assign m_out.command        = r_ores.command;
    assign m_out.voice_index    = r_ores.voice_index;
    assign m_out.note_number    = r_ores.note_number;
    assign m_out.level_value    = r_ores.level_value;
    assign m_out.program_number = r_ores.program_number;
    assign m_out.rhythm_mask    = r_ores.rhythm_mask;
    assign m_out.last           = r_ores.last;

    logic [7:0] b;
    logic       in_xfer;
    logic       is_fm, is_psg, is_ch;
    logic [4:0] vidx;
    logic [3:0] lvl;
    logic [3:0] dbit;
    logic       hit;
    mva_pkg::t_voice nv;
    mva_pkg::t_result res;

    assign b        = s_in.midi_byte;
    assign in_xfer  = s_in.valid && s_in.ready;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_count  = r_count;
        n_first  = r_first;
        n_drum   = r_drum;
        n_op     = r_op;
        n_ch     = r_ch;
        n_key    = r_key;
        n_data   = r_data;
        n_addr   = r_addr;
        n_end    = r_end;
        n_nres   = r_nres;
        n_stop   = r_stop;
        n_res    = r_res;
        n_pend   = r_pend;
        n_ovalid = r_ovalid && !m_out.ready;
        n_ores   = r_ores;
        we       = 1'b0;
        addr     = r_addr;
        wdata    = '0;
        is_fm    = (r_addr < AW'(PSG_BASE));
        is_psg   = !is_fm && (r_addr < AW'(CH_BASE));
        is_ch    = !is_fm && !is_psg;
        vidx     = is_fm ? 5'(r_addr) : 5'(r_addr - AW'(PSG_BASE));
        lvl      = r_data[6:3];
        dbit     = mva_pkg::drum_bit(r_first[6:0]);
        hit      = 1'b0;
        nv       = rdata;
        res      = '0;

        case (r_state)
            mva_pkg::ST_CLEAR: begin
                we = 1'b1;
                if (r_addr == AW'(DEPTH - 1)) begin
                    n_state = mva_pkg::ST_IDLE;
                    n_addr  = '0;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            mva_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_nres = '0;
                    n_stop = 1'b0;
                    n_pend = 1'b0;
                    if (b[7]) begin
                        if (b < 8'hF8) begin
                            n_status = (b[7:4] == mva_pkg::OP_NOTE_OFF ||
                                        b[7:4] == mva_pkg::OP_NOTE_ON ||
                                        b[7:4] == mva_pkg::OP_CTRL ||
                                        b[7:4] == mva_pkg::OP_PROG) ? b : 8'h00;
                            n_count = 1'b0;
                        end
                    end else if (r_status != 8'h00) begin
                        n_op = r_status[7:4];
                        n_ch = r_status[3:0];
                        if (!r_count) begin
                            n_first = b;
                            if (r_status[7:4] == mva_pkg::OP_PROG) begin
                                n_data = b[6:0];
                                n_addr = '0;
                                n_end  = AW'(PSG_BASE - 1);
                                n_state = mva_pkg::ST_READ;
                            end else begin
                                n_count = 1'b1;
                            end
                        end else begin
                            n_count = 1'b0;
                            n_key   = r_first[6:0];
                            n_data  = b[6:0];
                            if (r_status[7:4] == mva_pkg::OP_CTRL) begin
                                if (r_first[6:0] == mva_pkg::CC_VOLUME ||
                                    r_first[6:0] == mva_pkg::CC_EXPRESSION) begin
                                    if (r_status[3:0] == r_drum_ch) begin
                                        res.command     = mva_pkg::CMD_DRUM_VOL;
                                        res.level_value = b[6:3];
                                        res.last        = 1'b1;
                                        n_ores   = res;
                                        n_ovalid = 1'b1;
                                    end else begin
                                        // channel entry, then voices of that pool
                                        n_addr  = AW'(CH_BASE) + AW'(r_status[3:0]);
                                        n_state = mva_pkg::ST_READ;
                                        if (r_status[3:0] >= r_psg_ch) begin
                                            n_end = AW'(CH_BASE - 1);
                                        end else begin
                                            n_end = AW'(PSG_BASE - 1);
                                        end
                                    end
                                end
                            end else if (r_status[3:0] == r_drum_ch) begin
                                if (!dbit[3]) begin
                                    if (r_status[7:4] == mva_pkg::OP_NOTE_ON) begin
                                        n_drum = r_drum | (6'd1 << dbit[2:0]);
                                    end else begin
                                        n_drum = r_drum & ~(6'd1 << dbit[2:0]);
                                    end
                                    res.command     = mva_pkg::CMD_DRUM;
                                    res.rhythm_mask = n_drum;
                                    res.last        = 1'b1;
                                    n_ores   = res;
                                    n_ovalid = 1'b1;
                                end
                            end else begin
                                n_state = mva_pkg::ST_READ;
                                if (r_status[3:0] >= r_psg_ch) begin
                                    n_addr = AW'(PSG_BASE);
                                    n_end  = AW'(CH_BASE - 1);
                                end else begin
                                    n_addr = '0;
                                    n_end  = AW'(PSG_BASE - 1);
                                end
                            end
                        end
                    end
                end
            end
            mva_pkg::ST_READ: begin
                n_state = mva_pkg::ST_EVAL;
            end
            mva_pkg::ST_EVAL: begin
                // read data for r_addr is valid now
                res.voice_index = vidx;
                if (is_ch) begin
                    nv = rdata;
                    if (r_op == mva_pkg::OP_CTRL) begin
                        nv.level = lvl;
                    end else begin
                        nv.prog = r_data;
                    end
                    we = 1'b1;
                end else if (r_op == mva_pkg::OP_NOTE_ON) begin
                    if (!rdata.used) begin
                        hit = 1'b1;
                        nv.used = 1'b1;
                        nv.chan = r_ch;
                        nv.note = r_key;
                        we = 1'b1;
                        res.command     = is_fm ? mva_pkg::CMD_FM_ON : mva_pkg::CMD_PSG_ON;
                        res.note_number = r_key;
                        res.level_value = rdata.level;
                        res.program_number = is_fm ? rdata.prog : 7'd0;
                    end
                end else if (r_op == mva_pkg::OP_NOTE_OFF) begin
                    if (rdata.used && rdata.chan == r_ch && rdata.note == r_key) begin
                        hit = 1'b1;
                        nv.used = 1'b0;
                        we = 1'b1;
                        res.command     = is_fm ? mva_pkg::CMD_FM_OFF : mva_pkg::CMD_PSG_OFF;
                        res.note_number = r_key;
                        res.level_value = is_fm ? rdata.level : 4'd0;
                        res.program_number = is_fm ? rdata.prog : 7'd0;
                    end
                end else if (rdata.chan == r_ch) begin
                    hit = 1'b1;
                    we  = 1'b1;
                    if (r_op == mva_pkg::OP_CTRL) begin
                        nv.level = lvl;
                        res.command     = is_fm ? mva_pkg::CMD_FM_VOL : mva_pkg::CMD_PSG_VOL;
                        res.level_value = lvl;
                        res.program_number = is_fm ? rdata.prog : 7'd0;
                    end else begin
                        nv.prog = r_data;
                        res.command     = mva_pkg::CMD_FM_VOL;
                        res.level_value = rdata.level;
                        res.program_number = r_data;
                    end
                end
                wdata = nv;
                if (hit && r_op == mva_pkg::OP_NOTE_ON) begin
                    n_stop = 1'b1;
                end
                if (hit && r_nres < 5'(mva_pkg::MAX_RESULTS)) begin
                    n_nres = r_nres + 5'd1;
                    n_res  = res;
                    n_pend = 1'b1;
                    // a pending one is now known not last
                    if (r_pend) begin
                        n_ores   = r_res;
                        n_ovalid = 1'b1;
                    end
                end
                n_state = mva_pkg::ST_OUT;
            end
            mva_pkg::ST_OUT: begin
                // wait until the output register is free, then step on
                if (!r_ovalid) begin
                    if (r_addr == r_end || r_stop) begin
                        if (r_pend) begin
                            n_ores      = r_res;
                            n_ores.last = 1'b1;
                            n_ovalid    = 1'b1;
                            n_pend      = 1'b0;
                        end
                        n_state = mva_pkg::ST_IDLE;
                    end else begin
                        if (is_ch) begin
                            n_addr = (r_ch >= r_psg_ch) ? AW'(PSG_BASE) : '0;
                        end else begin
                            n_addr = r_addr + AW'(1);
                        end
                        addr    = n_addr;
                        n_state = mva_pkg::ST_EVAL;
                    end
                end
            end
            default: n_state = mva_pkg::ST_IDLE;
        endcase
        if (r_state == mva_pkg::ST_IDLE || r_state == mva_pkg::ST_READ) begin
            addr = (r_state == mva_pkg::ST_IDLE) ? n_addr : r_addr;
        end
    end

endmodule

// ===== rtl/mva_ram.sv =====
// ----------------------------------------------------------------------------
// mva_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module mva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== rtl/mva_checker.sv =====
// ----------------------------------------------------------------------------
// mva_checker
// port level checks of the voice allocator
// ----------------------------------------------------------------------------
module mva_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] out_command,
    input logic [4:0] out_voice,
    input logic [5:0] out_mask
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_command))
        else $error("command dropped while stalled");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready)
        else $error("byte taken while command pending");
    a_drum_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_command == mva_pkg::CMD_DRUM |-> out_voice == 5'd0 && out_mask[5])
        else $error("drum command malformed");
    a_in_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !out_valid || !in_ready)
        else $error("ready after transfer with output");
endmodule

bind midi_voice_allocator_core mva_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(s_in.valid), .in_ready(s_in.ready),
    .out_valid(m_out.valid), .out_ready(m_out.ready),
    .out_command(m_out.command), .out_voice(m_out.voice_index),
    .out_mask(m_out.rhythm_mask)
);
